[design/lcsle_pkg.sv]
package lcsle_pkg;

  // Default sizes for the top level's parameters.
  localparam int DEF_MAX_LEN     = 64;
  localparam int DEF_SYMBOL_BITS = 8;

  localparam int OP_W      = 2;
  localparam int SYM_IN_W  = 8;
  localparam int LEN_OUT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_COMPUTE       = 2'd2,
    OP_UNUSED        = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append_a;  // store the incoming symbol in the first string
    logic append_b;  // store the incoming symbol in the second string
    logic start;     // a compute item was taken: rewind the row and column counters
    logic row_rd;    // fetch the first-string symbol of the current row
    logic issue;     // fetch the operands of the current cell
    logic finish;    // load the result register and clear both strings
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // either string holds no symbols
    logic last_col;  // the column counter is on the last cell of the row
    logic last_row;  // the row counter is on the last row
    logic out_free;  // the result register can take a new item
  } sts_t;

endpackage

[design/lcsle_ctrl.sv]
module lcsle_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  lcsle_pkg::op_t       in_op,
  output logic                 in_tready,
  input  lcsle_pkg::sts_t      sts,
  output lcsle_pkg::cmd_t      cmd
);
  import lcsle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_CELL,
    S_WAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;
  logic   fire;

  assign fire      = in_tvalid & ready_r;
  assign in_tready = ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          unique case (in_op)
            OP_APPEND_FIRST:  cmd.append_a = 1'b1;
            OP_APPEND_SECOND: cmd.append_b = 1'b1;
            OP_COMPUTE: begin
              cmd.start = 1'b1;
              state_nxt = sts.empty ? S_DONE : S_ROW;
            end
            default: ;
          endcase
        end
      end
      S_ROW: begin
        cmd.row_rd = 1'b1;
        state_nxt  = S_CELL;
      end
      S_CELL: begin
        cmd.issue = 1'b1;
        if (sts.last_col) begin
          state_nxt = sts.last_row ? S_WAIT : S_ROW;
        end
      end
      S_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

[design/lcsle_dp.sv]
module lcsle_dp #(
  parameter int MAX_LEN     = lcsle_pkg::DEF_MAX_LEN,
  parameter int SYMBOL_BITS = lcsle_pkg::DEF_SYMBOL_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lcsle_pkg::SYM_IN_W-1:0]  in_symbol,
  input  lcsle_pkg::cmd_t                 cmd,
  output lcsle_pkg::sts_t                 sts,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [lcsle_pkg::LEN_OUT_W-1:0] out_len,
  output logic                            out_trunc
);
  import lcsle_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  // String stores and the kept table row; row entry k holds column k+1.
  logic [SYMBOL_BITS-1:0] mem_a [MAX_LEN];
  logic [SYMBOL_BITS-1:0] mem_b [MAX_LEN];
  logic [CW-1:0]          mem_row [MAX_LEN];

  logic [CW-1:0]          n1_r, n2_r;
  logic                   ovf_r;
  logic [AW-1:0]          i_r, j_r;
  logic [SYMBOL_BITS-1:0] a_q_r, b_q_r;
  logic [CW-1:0]          up_q_r;
  logic                   p_vld_r, p_first_r;
  logic [AW-1:0]          p_j_r;
  logic [CW-1:0]          left_r, diag_r;
  logic                   out_vld_r, out_trunc_r;
  logic [LEN_OUT_W-1:0]   out_len_r;

  logic [SYMBOL_BITS-1:0] sym;
  logic [CW-1:0]          up, cell_score, n1_m1, n2_m1;

  assign sym   = SYMBOL_BITS'(in_symbol);
  assign n1_m1 = n1_r - CW'(1);
  assign n2_m1 = n2_r - CW'(1);

  assign sts.empty    = (n1_r == '0) || (n2_r == '0);
  assign sts.last_col = (CW'(j_r) == n2_m1);
  assign sts.last_row = (CW'(i_r) == n1_m1);
  assign sts.out_free = !out_vld_r || out_tready;

  // On the first row the cell above is a border cell.
  assign up         = p_first_r ? '0 : up_q_r;
  assign cell_score = (a_q_r == b_q_r) ? (diag_r + CW'(1)) : ((up > left_r) ? up : left_r);

  always_ff @(posedge clk) begin
    if (cmd.append_a && (n1_r < CW'(MAX_LEN))) begin
      mem_a[n1_r[AW-1:0]] <= sym;
    end
    if (cmd.append_b && (n2_r < CW'(MAX_LEN))) begin
      mem_b[n2_r[AW-1:0]] <= sym;
    end
    if (cmd.row_rd) begin
      a_q_r <= mem_a[i_r];
    end
    if (cmd.issue) begin
      b_q_r  <= mem_b[j_r];
      up_q_r <= mem_row[j_r];
    end
    if (p_vld_r) begin
      mem_row[p_j_r] <= cell_score;
    end
  end

  always_ff @(posedge clk) begin
    p_j_r     <= j_r;
    p_first_r <= (i_r == '0);
    if (cmd.issue && (j_r == '0)) begin
      left_r <= '0;
      diag_r <= '0;
    end else if (p_vld_r) begin
      left_r <= cell_score;
      diag_r <= up;
    end
    if (cmd.finish) begin
      out_len_r   <= sts.empty ? '0 : LEN_OUT_W'(left_r);
      out_trunc_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_r      <= '0;
      n2_r      <= '0;
      ovf_r     <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.issue;
      if (cmd.append_a) begin
        if (n1_r < CW'(MAX_LEN)) n1_r <= n1_r + CW'(1);
        else                     ovf_r <= 1'b1;
      end
      if (cmd.append_b) begin
        if (n2_r < CW'(MAX_LEN)) n2_r <= n2_r + CW'(1);
        else                     ovf_r <= 1'b1;
      end
      if (cmd.start) begin
        i_r <= '0;
        j_r <= '0;
      end else if (cmd.issue) begin
        if (sts.last_col) begin
          j_r <= '0;
          i_r <= i_r + AW'(1);
        end else begin
          j_r <= j_r + AW'(1);
        end
      end
      if (cmd.finish) begin
        n1_r      <= '0;
        n2_r      <= '0;
        ovf_r     <= 1'b0;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_len    = out_len_r;
  assign out_trunc  = out_trunc_r;

endmodule

[design/lcs_length_engine_core.sv]
// Append items are taken one per cycle while no compute is in progress and give no result.
// A compute item with n1 and n2 symbols loaded runs a row fetch and one cell a cycle for each
// row, then a drain state and the result write; when either string is empty it goes straight
// to the result write. out_tvalid rises as in_tready returns, both held back only while an
// earlier result still waits on out_tready; appends flow while a result waits.
// rst_n (synchronous, active low) empties both strings, clears the overflow flag and out_tvalid.
module lcs_length_engine_core #(
  parameter int MAX_LEN     = lcsle_pkg::DEF_MAX_LEN,
  parameter int SYMBOL_BITS = lcsle_pkg::DEF_SYMBOL_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] symbol
  input  logic [lcsle_pkg::OP_W-1:0] in_tuser,   // [1:0] operation
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata   // [6:0] lcs_length, [7] truncated
);
  import lcsle_pkg::*;

  // The controller sequences rows and cells; the datapath holds the strings,
  // the kept row of the table, the cell arithmetic and the result register.
  cmd_t                 cmd;
  sts_t                 sts;
  logic [LEN_OUT_W-1:0] res_len;
  logic                 res_trunc;

  lcsle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (op_t'(in_tuser)),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcsle_dp #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_symbol  (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_len    (res_len),
    .out_trunc  (res_trunc)
  );

  // The result item packs the length in the low bits and the overflow flag above it.
  assign out_tdata = {res_trunc, res_len};

endmodule
